// ===== rtl/core/usp_pkg.sv =====
// ============================================================================
// usp_pkg
// Shared widths, constants and types of the Ulam spiral prime cell core.
// ============================================================================
package usp_pkg;

    localparam int unsigned COORD_W      = 12;
    localparam int unsigned SIDE_W       = 13;
    localparam int unsigned VALUE_W      = 26;
    localparam int unsigned MAX_SIDE_DEF = 4096;
    localparam logic [SIDE_W-1:0] SIDE_RESET = 13'd4096;

    // offset of the cell from the layer corner, at most 8 * layer
    localparam int unsigned OFF_W = 15;

    // trial divisors stay below 2^14, their squares below 2^27
    localparam int unsigned K_W   = 14;
    localparam int unsigned KSQ_W = 27;

    // remainder unit: DIG_W dividend bits per cycle
    localparam int unsigned DIG_W      = 4;
    localparam int unsigned DIV_CYCLES = 7;
    localparam int unsigned SH_W       = DIG_W * DIV_CYCLES;

    localparam int unsigned Q_DEPTH = 2;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_STEP,
        BK_BOUND
    } t_bk_state;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
    } t_q_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== rtl/core/usp_if.sv =====
// ============================================================================
// usp_if
// Valid/ready channels for cell coordinates in and cell results out.
// ============================================================================
interface usp_in_if;
    logic                        valid;
    logic                        ready;
    logic [usp_pkg::COORD_W-1:0] col;
    logic [usp_pkg::COORD_W-1:0] row;

    modport source (output valid, output col, output row, input ready);
    modport sink   (input valid, input col, input row, output ready);
endinterface

interface usp_out_if;
    logic                        valid;
    logic                        ready;
    logic [usp_pkg::VALUE_W-1:0] cell_value;
    logic                        is_prime;

    modport source (output valid, output cell_value, output is_prime, input ready);
    modport sink   (input valid, input cell_value, input is_prime, output ready);
endinterface

// ===== rtl/core/ulam_spiral_prime_cell_core.sv =====
// ============================================================================
// ulam_spiral_prime_cell_core
// Maps grid cells to Ulam spiral numbers and tests them for primality.
// ============================================================================
//  channel   dir  handshake            payload
//  i_cell    in   valid/ready          col[11:0], row[11:0]
//  o_cell    out  valid/ready          cell_value[25:0], is_prime
//  i_cfg_*   in   write enable only    side[12:0]
//
//  Mapping front: stage registers s1, s2 and s3, then a two entry queue.
//  Prime test: numbers below 4 are decided straight from the queue, others
//  run per divisor pair the remainder steps at 4 bits each, then step and
//  bound; one pair for 2 and 3 and one per k with k*k <= u.
//  Reset is synchronous and clears the valids, queue, FSM and side to 4096.
//  The front keeps taking cells while the queue has room; results wait in
//  the output register until taken.
module ulam_spiral_prime_cell_core #(
    parameter int unsigned MAX_SIDE = usp_pkg::MAX_SIDE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [usp_pkg::SIDE_W-1:0] i_cfg_wdata,
    usp_in_if.sink                     i_cell,
    usp_out_if.source                  o_cell
);

    usp_pkg::t_q_push            w_push;
    usp_pkg::t_q_stat            w_stat;
    logic                        w_pop;
    logic [usp_pkg::VALUE_W-1:0] w_qdata;

    usp_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cell      (i_cell),
        .i_q_stat    (w_stat),
        .o_q_push    (w_push)
    );

    usp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_stat  (w_stat),
        .o_data  (w_qdata)
    );

    usp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_stat),
        .i_q_data (w_qdata),
        .o_q_pop  (w_pop),
        .o_cell   (o_cell)
    );

endmodule

// ===== rtl/core/usp_front.sv =====
// ============================================================================
// usp_front
// Holds the grid side, maps each cell to its spiral number in a three stage
// pipeline and pushes the number into the queue.
// ============================================================================
module usp_front #(
    parameter int unsigned MAX_SIDE = usp_pkg::MAX_SIDE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [usp_pkg::SIDE_W-1:0]  i_cfg_wdata,
    usp_in_if.sink                      i_cell,
    input  usp_pkg::t_q_stat            i_q_stat,
    output usp_pkg::t_q_push            o_q_push
);

    localparam int unsigned CMP_W = 17;
    localparam logic [CMP_W-1:0] MAX_N = CMP_W'(MAX_SIDE);

    logic [usp_pkg::SIDE_W-1:0]  r_side;
    logic                        r_s1_v, r_s2_v, r_s3_v;
    logic [12:0]                 r_s1_sx, r_s1_sy;
    logic [12:0]                 r_s2_m;
    logic [usp_pkg::OFF_W-1:0]   r_s2_off, r_s3_off;
    logic [usp_pkg::VALUE_W-1:0] r_s3_sq;

    logic                        w_adv;
    logic [usp_pkg::SIDE_W-1:0]  w_n;
    logic [11:0]                 w_c;
    logic [12:0]                 w_sx, w_sy, w_nsx, w_nsy;
    logic [11:0]                 w_ax, w_ay, w_l;
    logic signed [16:0]          w_l17, w_sx17, w_sy17, w_off17;
    logic [usp_pkg::VALUE_W-1:0] w_sq;

    // clamp side, center is n/2
    assign w_n  = ({4'd0, r_side} > MAX_N) ? MAX_N[usp_pkg::SIDE_W-1:0] : r_side;
    assign w_c  = w_n[12:1];
    assign w_sx = {1'b0, i_cell.col} - {1'b0, w_c};
    assign w_sy = {1'b0, i_cell.row} - {1'b0, w_c};

    assign w_adv        = !(r_s3_v && i_q_stat.full);
    assign i_cell.ready = w_adv;

    // stage 2: layer and edge offset
    assign w_nsx = 13'd0 - r_s1_sx;
    assign w_nsy = 13'd0 - r_s1_sy;
    assign w_ax  = r_s1_sx[12] ? w_nsx[11:0] : r_s1_sx[11:0];
    assign w_ay  = r_s1_sy[12] ? w_nsy[11:0] : r_s1_sy[11:0];
    assign w_l   = (w_ax > w_ay) ? w_ax : w_ay;

    assign w_l17  = $signed({5'd0, w_l});
    assign w_sx17 = $signed({{4{r_s1_sx[12]}}, r_s1_sx});
    assign w_sy17 = $signed({{4{r_s1_sy[12]}}, r_s1_sy});

    always_comb begin
        priority if (!r_s1_sy[12] && (w_ay == w_l)) begin
            w_off17 = w_l17 - w_sx17;                       // top edge
        end else if ((r_s1_sx[12] || (r_s1_sx == 13'd0)) && (w_ax == w_l)) begin
            w_off17 = 17'sd3 * w_l17 - w_sy17;              // left edge
        end else if ((r_s1_sy[12] || (r_s1_sy == 13'd0)) && (w_ay == w_l)) begin
            w_off17 = 17'sd5 * w_l17 + w_sx17;              // bottom edge
        end else begin
            w_off17 = 17'sd7 * w_l17 + w_sy17;              // right edge
        end
    end

    assign w_sq = {13'd0, r_s2_m} * {13'd0, r_s2_m};

    assign o_q_push.valid = r_s3_v && !i_q_stat.full;
    assign o_q_push.value = r_s3_sq - {11'd0, r_s3_off};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= usp_pkg::SIDE_RESET;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_side <= i_cfg_wdata;
            end
            if (w_adv) begin
                r_s1_v <= i_cell.valid;
                r_s2_v <= r_s1_v;
                r_s3_v <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_sx  <= w_sx;
            r_s1_sy  <= w_sy;
            r_s2_m   <= {w_l, 1'b1};
            r_s2_off <= w_off17[usp_pkg::OFF_W-1:0];
            r_s3_sq  <= w_sq;
            r_s3_off <= r_s2_off;
        end
    end

endmodule

// ===== rtl/core/usp_queue.sv =====
// ============================================================================
// usp_queue
// Short FIFO of spiral numbers between the mapping front and the prime test.
// ============================================================================
module usp_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  usp_pkg::t_q_push            i_push,
    input  logic                        i_pop,
    output usp_pkg::t_q_stat            o_stat,
    output logic [usp_pkg::VALUE_W-1:0] o_data
);

    localparam int unsigned PTR_W = (usp_pkg::Q_DEPTH > 1) ? $clog2(usp_pkg::Q_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(usp_pkg::Q_DEPTH + 1);

    logic [usp_pkg::VALUE_W-1:0] r_mem [usp_pkg::Q_DEPTH];
    logic [PTR_W-1:0]            r_wp, r_rp;
    logic [CNT_W-1:0]            r_cnt;

    assign o_stat.full  = (r_cnt == CNT_W'(usp_pkg::Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_data       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.valid) begin
                r_wp <= (r_wp == PTR_W'(usp_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(usp_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            unique case ({i_push.valid, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wp] <= i_push.value;
        end
    end

endmodule

// ===== rtl/core/usp_back.sv =====
// ============================================================================
// usp_back
// Trial division by 2, 3 and then k, k+2 for k = 5, 11, ... while k*k <= u.
// Two remainder units share the dividend shifter, four bits per cycle.
// ============================================================================
module usp_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  usp_pkg::t_q_stat            i_q_stat,
    input  logic [usp_pkg::VALUE_W-1:0] i_q_data,
    output logic                        o_q_pop,
    usp_out_if.source                   o_cell
);

    localparam int unsigned CNT_W = $clog2(usp_pkg::DIV_CYCLES);
    localparam int unsigned K_W   = usp_pkg::K_W;

    usp_pkg::t_bk_state          r_state, n_state;
    logic [usp_pkg::VALUE_W-1:0] r_u, n_u;
    logic [usp_pkg::SH_W-1:0]    r_sh, n_sh;
    logic [K_W-1:0]              r_ra, n_ra, r_rb, n_rb;
    logic [K_W-1:0]              r_da, n_da, r_db, n_db;
    logic [K_W-1:0]              r_k, n_k;
    logic [usp_pkg::KSQ_W-1:0]   r_ksq, n_ksq;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic                        r_first, n_first;
    logic                        r_ov, n_ov;
    logic [usp_pkg::VALUE_W-1:0] r_val, n_val;
    logic                        r_prime, n_prime;

    logic                        w_out_free;

    // four restoring remainder steps; r < d on entry and exit
    function automatic logic [K_W-1:0] rem_step(
        input logic [K_W-1:0]           r,
        input logic [usp_pkg::DIG_W-1:0] bits,
        input logic [K_W-1:0]           d
    );
        logic [K_W:0]   t;
        logic [K_W-1:0] acc;
        acc = r;
        for (int i = usp_pkg::DIG_W - 1; i >= 0; i--) begin
            t = {acc, bits[i]};
            if (t >= {1'b0, d}) begin
                t = t - {1'b0, d};
            end
            acc = t[K_W-1:0];
        end
        return acc;
    endfunction

    assign w_out_free = !r_ov || o_cell.ready;

    assign o_cell.valid      = r_ov;
    assign o_cell.cell_value = r_val;
    assign o_cell.is_prime   = r_prime;

    always_comb begin
        n_state = r_state;
        n_u     = r_u;
        n_sh    = r_sh;
        n_ra    = r_ra;
        n_rb    = r_rb;
        n_da    = r_da;
        n_db    = r_db;
        n_k     = r_k;
        n_ksq   = r_ksq;
        n_cnt   = r_cnt;
        n_first = r_first;
        n_ov    = r_ov && !o_cell.ready;
        n_val   = r_val;
        n_prime = r_prime;
        o_q_pop = 1'b0;

        unique case (r_state)
            usp_pkg::BK_IDLE: begin
                if (!i_q_stat.empty && w_out_free) begin
                    o_q_pop = 1'b1;
                    if (i_q_data < usp_pkg::VALUE_W'(4)) begin
                        // 0 and 1 are not prime, 2 and 3 are
                        n_ov    = 1'b1;
                        n_prime = (i_q_data > usp_pkg::VALUE_W'(1));
                        n_val   = n_prime ? '0 : i_q_data;
                    end else begin
                        n_u     = i_q_data;
                        n_sh    = usp_pkg::SH_W'(i_q_data);
                        n_ra    = '0;
                        n_rb    = '0;
                        n_da    = K_W'(2);
                        n_db    = K_W'(3);
                        n_cnt   = '0;
                        n_first = 1'b1;
                        n_state = usp_pkg::BK_DIV;
                    end
                end
            end
            usp_pkg::BK_DIV: begin
                n_ra  = rem_step(r_ra, r_sh[usp_pkg::SH_W-1 -: usp_pkg::DIG_W], r_da);
                n_rb  = rem_step(r_rb, r_sh[usp_pkg::SH_W-1 -: usp_pkg::DIG_W], r_db);
                n_sh  = r_sh << usp_pkg::DIG_W;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(usp_pkg::DIV_CYCLES - 1)) begin
                    n_state = usp_pkg::BK_STEP;
                end
            end
            usp_pkg::BK_STEP: begin
                if ((r_ra == '0) || (r_rb == '0)) begin
                    n_ov    = 1'b1;
                    n_val   = r_u;
                    n_prime = 1'b0;
                    n_state = usp_pkg::BK_IDLE;
                end else begin
                    if (r_first) begin
                        n_k     = K_W'(5);
                        n_ksq   = usp_pkg::KSQ_W'(25);
                        n_first = 1'b0;
                    end else begin
                        // (k+6)^2 = k^2 + 12k + 36
                        n_k   = r_k + K_W'(6);
                        n_ksq = r_ksq + {r_k, 3'b000} + {1'b0, r_k, 2'b00}
                              + usp_pkg::KSQ_W'(36);
                    end
                    n_state = usp_pkg::BK_BOUND;
                end
            end
            usp_pkg::BK_BOUND: begin
                if (r_ksq > {1'b0, r_u}) begin
                    n_ov    = 1'b1;
                    n_val   = '0;
                    n_prime = 1'b1;
                    n_state = usp_pkg::BK_IDLE;
                end else begin
                    n_da    = r_k;
                    n_db    = r_k + K_W'(2);
                    n_sh    = usp_pkg::SH_W'(r_u);
                    n_ra    = '0;
                    n_rb    = '0;
                    n_cnt   = '0;
                    n_state = usp_pkg::BK_DIV;
                end
            end
            default: begin
                n_state = usp_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= usp_pkg::BK_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u     <= n_u;
        r_sh    <= n_sh;
        r_ra    <= n_ra;
        r_rb    <= n_rb;
        r_da    <= n_da;
        r_db    <= n_db;
        r_k     <= n_k;
        r_ksq   <= n_ksq;
        r_cnt   <= n_cnt;
        r_first <= n_first;
        r_val   <= n_val;
        r_prime <= n_prime;
    end

endmodule
